@@ rtl/ret_pkg.sv @@
// Shared types and constants for the radar echo trail ager.
// Used by ret_age_ram, ret_engine and radar_echo_trail_ager_unit.
`default_nettype none

package ret_pkg;

   localparam int AGE_W    = 4;
   localparam int ECHO_W   = 8;
   localparam int SPOKE_W  = 11;
   localparam int RADIUS_W = 9;
   localparam int LEN_W    = 10;

   localparam logic KIND_ECHO  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   localparam logic [1:0] REG_STRONG  = 2'd0;
   localparam logic [1:0] REG_WEAK    = 2'd1;
   localparam logic [1:0] REG_RECOLOR = 2'd2;

   localparam logic [7:0] STRONG_RESET = 8'd200;
   localparam logic [7:0] WEAK_RESET   = 8'd50;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT,
      ST_TAIL
   } ret_state_type;

   typedef struct packed {
      logic [ECHO_W-1:0] strong_threshold;
      logic [ECHO_W-1:0] weak_threshold;
      logic              recolour_enable;
   } ret_cfg_type;

endpackage

`default_nettype wire

@@ rtl/ret_age_ram.sv @@
// Age store: single write port, single registered read port.
// Depends on ret_pkg for the age width.
`default_nettype none

module ret_age_ram #(
   parameter int DEPTH  = 1048576,
   parameter int ADDR_W = 20
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [ret_pkg::AGE_W-1:0]  wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [ret_pkg::AGE_W-1:0]  rd_data
);

   logic [ret_pkg::AGE_W-1:0] mem [DEPTH];
   logic [ret_pkg::AGE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ret_engine.sv @@
// Sequencer for the trail ager: read-modify-write of one age, tail and full sweeps,
// result register. Depends on ret_pkg; drives the ports of ret_age_ram.
`default_nettype none

module ret_engine #(
   parameter int SPOKE_COUNT = 2048,
   parameter int SPOKE_CELLS = 512,
   parameter int AGE_LIMIT   = 15,
   parameter int ADDR_W      = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ret_pkg::ret_cfg_type          cfg,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          req_kind,
   input  wire logic [ret_pkg::SPOKE_W-1:0]   req_spoke,
   input  wire logic [ret_pkg::RADIUS_W-1:0]  req_radius,
   input  wire logic [ret_pkg::ECHO_W-1:0]    req_echo,
   input  wire logic [ret_pkg::LEN_W-1:0]     req_len,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [ret_pkg::ECHO_W-1:0]    rsp_echo,
   output logic      [ret_pkg::AGE_W-1:0]     rsp_age,
   output logic                               rsp_recolour,
   output logic                               wr_en,
   output logic      [ADDR_W-1:0]             wr_addr,
   output logic      [ret_pkg::AGE_W-1:0]     wr_data,
   output logic                               rd_en,
   output logic      [ADDR_W-1:0]             rd_addr,
   input  wire logic [ret_pkg::AGE_W-1:0]     rd_data
);

   localparam int STORE  = SPOKE_COUNT * SPOKE_CELLS;
   localparam int CELL_W = $clog2(SPOKE_CELLS);
   localparam int AGE_CAP = (AGE_LIMIT < 15) ? AGE_LIMIT : 15;
   localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE - 1);
   localparam logic [ADDR_W-1:0] CELLS_A    = ADDR_W'(SPOKE_CELLS);
   localparam logic [CELL_W-1:0] CELL_LAST  = CELL_W'(SPOKE_CELLS - 1);
   localparam logic [ret_pkg::AGE_W-1:0] AGE_CAP_V = ret_pkg::AGE_W'(AGE_CAP);

   ret_pkg::ret_state_type state_ff, state_in;
   logic [ADDR_W-1:0]            addr_ff, addr_in;
   logic [CELL_W-1:0]            cell_ff, cell_in;
   logic [ret_pkg::ECHO_W-1:0]   echo_ff, echo_in;
   logic                         tail_ff, tail_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ret_pkg::ECHO_W-1:0]   rsp_echo_ff;
   logic [ret_pkg::AGE_W-1:0]    rsp_age_ff, rsp_age_in;
   logic                         rsp_flag_ff, rsp_flag_in;
   logic                         load_out;
   logic                         slot_free;
   logic                         in_range;
   logic                         tail_cond;
   logic [ADDR_W-1:0]            req_addr;
   logic [ret_pkg::AGE_W-1:0]    new_age;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign in_range  = (32'(req_spoke) < SPOKE_COUNT) && (32'(req_radius) < SPOKE_CELLS);
   assign tail_cond = ({1'b0, req_radius} + 10'd1) >= req_len;
   assign req_addr  = ADDR_W'(req_spoke) * CELLS_A + ADDR_W'(req_radius);

   always_comb begin
      if (echo_ff >= cfg.strong_threshold) begin
         new_age = ret_pkg::AGE_W'(1);
      end else if (rd_data != '0 && rd_data < AGE_CAP_V) begin
         new_age = rd_data + ret_pkg::AGE_W'(1);
      end else begin
         new_age = rd_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      cell_in     = cell_ff;
      echo_in     = echo_ff;
      tail_in     = tail_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = req_addr;
      req_tready  = 1'b0;
      load_out    = 1'b0;
      rsp_age_in  = '0;
      rsp_flag_in = 1'b0;
      case (state_ff)
         ret_pkg::ST_WIPE: begin
            wr_en = 1'b1;
            if (addr_ff == STORE_LAST) begin
               state_in = ret_pkg::ST_IDLE;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         ret_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               echo_in = req_echo;
               addr_in = req_addr;
               cell_in = CELL_W'(req_radius);
               tail_in = in_range && tail_cond;
               if (req_kind == ret_pkg::KIND_CLEAR) begin
                  addr_in  = '0;
                  state_in = ret_pkg::ST_WIPE;
               end else if (in_range && !tail_cond) begin
                  rd_en    = 1'b1;
                  state_in = ret_pkg::ST_LOOKUP;
               end else begin
                  state_in = ret_pkg::ST_EMIT;
               end
            end
         end
         ret_pkg::ST_LOOKUP: begin
            if (slot_free) begin
               load_out    = 1'b1;
               rsp_age_in  = new_age;
               rsp_flag_in = cfg.recolour_enable && (echo_ff < cfg.weak_threshold);
               wr_en       = 1'b1;
               wr_data     = new_age;
               state_in    = ret_pkg::ST_IDLE;
            end
         end
         ret_pkg::ST_EMIT: begin
            if (slot_free) begin
               load_out = 1'b1;
               state_in = tail_ff ? ret_pkg::ST_TAIL : ret_pkg::ST_IDLE;
            end
         end
         ret_pkg::ST_TAIL: begin
            wr_en = 1'b1;
            if (cell_ff == CELL_LAST) begin
               state_in = ret_pkg::ST_IDLE;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
               cell_in = cell_ff + CELL_W'(1);
            end
         end
         default: begin
            state_in = ret_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ret_pkg::ST_WIPE;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      echo_ff <= echo_in;
      tail_ff <= tail_in;
      if (load_out) begin
         rsp_echo_ff <= echo_ff;
         rsp_age_ff  <= rsp_age_in;
         rsp_flag_ff <= rsp_flag_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_echo     = rsp_echo_ff;
   assign rsp_age      = rsp_age_ff;
   assign rsp_recolour = rsp_flag_ff;

   a_lookup_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ret_pkg::ST_LOOKUP) |->
         ($past(rd_en) || $past(state_ff == ret_pkg::ST_LOOKUP)))
      else $error("lookup without a pending read");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> slot_free)
      else $error("result register overwritten");

   a_tail_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ret_pkg::ST_TAIL && cell_ff == CELL_LAST) |=>
         (state_ff == ret_pkg::ST_IDLE))
      else $error("tail sweep overran the spoke");

   a_age_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_age_ff <= AGE_CAP_V))
      else $error("age above limit");

endmodule

`default_nettype wire

@@ rtl/radar_echo_trail_ager_unit.sv @@
// Radar echo trail ager: top level with the register port, age store and sequencer.
// Depends on ret_pkg, ret_age_ram and ret_engine.
//
// Usage: requests enter on req_* (tuser = kind, tdata = spoke, radius, echo,
// spoke_length). An echo sample yields one result on rsp_* (tdata = echo_out,
// trail_age; tuser = recolour); a clear request yields none.
// A result is loaded into the output register from ST_LOOKUP or ST_EMIT, which
// follow acceptance in ST_IDLE, once that register is free. A sample that touches
// one cell has its age read and rewritten through ST_LOOKUP; no new request is
// accepted until the sequencer is back in ST_IDLE. A last-cell sample zeroes the rest
// of the spoke from its radius in ST_TAIL, one cell a cycle; a clear zeroes the store.
// Reset: registers return to their defaults and the store is zeroed by a sweep of all
// SPOKE_COUNT * SPOKE_CELLS cells, during which req_tready stays low; register
// writes are taken throughout.
// Stall: a result waits in an output register while the next request is accepted;
// the sequencer holds its update until that register is free.
`default_nettype none

module radar_echo_trail_ager_unit #(
   parameter int SPOKE_COUNT = 2048,
   parameter int SPOKE_CELLS = 512,
   parameter int AGE_LIMIT   = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [10:0] spoke, [19:11] radius, [27:20] echo, [37:28] spoke_length, [39:38] zero
   input  wire logic [39:0] req_tdata,
   // [0] kind
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] echo_out, [11:8] trail_age, [15:12] zero
   output logic      [15:0] rsp_tdata,
   // [0] recolour
   output logic             rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int STORE  = SPOKE_COUNT * SPOKE_CELLS;
   localparam int ADDR_W = $clog2(STORE);

   logic [7:0] strong_ff, strong_in;
   logic [7:0] weak_ff, weak_in;
   logic       recolour_en_ff, recolour_en_in;
   logic       csr_write;
   ret_pkg::ret_cfg_type cfg;

   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ret_pkg::AGE_W-1:0]    wr_data;
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic [ret_pkg::AGE_W-1:0]    rd_data;
   logic [ret_pkg::ECHO_W-1:0]   rsp_echo;
   logic [ret_pkg::AGE_W-1:0]    rsp_age;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      strong_in      = strong_ff;
      weak_in        = weak_ff;
      recolour_en_in = recolour_en_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            ret_pkg::REG_STRONG:  strong_in      = csr_pwdata[7:0];
            ret_pkg::REG_WEAK:    weak_in        = csr_pwdata[7:0];
            ret_pkg::REG_RECOLOR: recolour_en_in = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strong_ff      <= ret_pkg::STRONG_RESET;
         weak_ff        <= ret_pkg::WEAK_RESET;
         recolour_en_ff <= 1'b0;
      end else begin
         strong_ff      <= strong_in;
         weak_ff        <= weak_in;
         recolour_en_ff <= recolour_en_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         ret_pkg::REG_STRONG:  csr_prdata = {24'd0, strong_ff};
         ret_pkg::REG_WEAK:    csr_prdata = {24'd0, weak_ff};
         ret_pkg::REG_RECOLOR: csr_prdata = {31'd0, recolour_en_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign cfg.strong_threshold = strong_ff;
   assign cfg.weak_threshold   = weak_ff;
   assign cfg.recolour_enable  = recolour_en_ff;

   ret_age_ram #(
      .DEPTH  (STORE),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ret_engine #(
      .SPOKE_COUNT (SPOKE_COUNT),
      .SPOKE_CELLS (SPOKE_CELLS),
      .AGE_LIMIT   (AGE_LIMIT),
      .ADDR_W      (ADDR_W)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_kind     (req_tuser),
      .req_spoke    (req_tdata[10:0]),
      .req_radius   (req_tdata[19:11]),
      .req_echo     (req_tdata[27:20]),
      .req_len      (req_tdata[37:28]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_echo     (rsp_echo),
      .rsp_age      (rsp_age),
      .rsp_recolour (rsp_tuser),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   assign rsp_tdata = {4'd0, rsp_age, rsp_echo};

endmodule

`default_nettype wire

@@ bench/radar_echo_trail_ager_unit_tb.sv @@
// Self-checking bench for radar_echo_trail_ager_unit: directed table, then randomized spoke
// sweeps and noise under several register settings, checked against a trail age predictor.
// Depends on ret_pkg and the RTL of radar_echo_trail_ager_unit.
`default_nettype none

module radar_echo_trail_ager_unit_tb;

   localparam int SPOKE_COUNT   = 2048;
   localparam int SPOKE_CELLS   = 512;
   localparam int AGE_LIMIT     = 15;
   localparam int AGE_CAP       = (AGE_LIMIT < 15) ? AGE_LIMIT : 15;
   localparam int STORE_CELLS   = SPOKE_COUNT * SPOKE_CELLS;
   localparam int CLOCK_PERIOD  = 12;
   localparam int SETTLE_CYCLES = SPOKE_CELLS + 16;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 310;
   localparam int HOLD_CYCLES   = 2500;
   localparam longint TIMEOUT_TIME = 64'd20_000_000 * CLOCK_PERIOD;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic                         kind;
      logic [ret_pkg::SPOKE_W-1:0]  spoke;
      logic [ret_pkg::RADIUS_W-1:0] radius;
      logic [ret_pkg::ECHO_W-1:0]   echo;
      logic [ret_pkg::LEN_W-1:0]    spoke_length;
   } echo_request_type;

   typedef struct packed {
      logic [ret_pkg::ECHO_W-1:0] echo_out;
      logic [ret_pkg::AGE_W-1:0]  trail_age;
      logic                       recolour;
   } echo_result_type;

   typedef struct packed {
      echo_request_type req;
      logic             typed;
      echo_result_type  want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 23;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd0, 10'd0}, 1'b1, '{8'd0, 4'd0, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd0, 10'd512}, 1'b1, '{8'd0, 4'd0, 1'b1}},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd255, 10'd512}, 1'b1, '{8'd255, 4'd1, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd10, 10'd512}, 1'b1, '{8'd10, 4'd2, 1'b1}},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd199, 10'd512}, 1'b1, '{8'd199, 4'd3, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd200, 10'd512}, 1'b1, '{8'd200, 4'd1, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd49, 10'd512}, 1'b1, '{8'd49, 4'd2, 1'b1}},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd50, 10'd512}, 1'b1, '{8'd50, 4'd3, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd2047, 9'd510, 8'd255, 10'd512}, 1'b1, '{8'd255, 4'd1, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd2047, 9'd511, 8'd255, 10'd512}, 1'b1, '{8'd255, 4'd0, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd2047, 9'd510, 8'd100, 10'd512}, 1'b1, '{8'd100, 4'd2, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd2047, 9'd0, 8'd255, 10'd1}, 1'b1, '{8'd255, 4'd0, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd2047, 9'd510, 8'd100, 10'd512}, 1'b1, '{8'd100, 4'd0, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd5, 9'd3, 8'd255, 10'd0}, 1'b1, '{8'd255, 4'd0, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd5, 9'd3, 8'd30, 10'd1023}, 1'b1, '{8'd30, 4'd0, 1'b1}},
      '{'{ret_pkg::KIND_ECHO, 11'd5, 9'd3, 8'd255, 10'd1023}, 1'b1, '{8'd255, 4'd1, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd1, 9'd511, 8'd255, 10'd1023}, 1'b1, '{8'd255, 4'd1, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd1, 9'd511, 8'd7, 10'd1023}, 1'b0, '0},
      '{'{ret_pkg::KIND_ECHO, 11'd1234, 9'd300, 8'd77, 10'd301}, 1'b0, '0},
      '{'{ret_pkg::KIND_ECHO, 11'd1234, 9'd299, 8'd77, 10'd301}, 1'b0, '0},
      '{'{ret_pkg::KIND_CLEAR, 11'd2047, 9'd511, 8'd255, 10'd1023}, 1'b0, '0},
      '{'{ret_pkg::KIND_ECHO, 11'd0, 9'd0, 8'd100, 10'd512}, 1'b1, '{8'd100, 4'd0, 1'b0}},
      '{'{ret_pkg::KIND_ECHO, 11'd1, 9'd511, 8'd60, 10'd1023}, 1'b1, '{8'd60, 4'd0, 1'b0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bit [ret_pkg::AGE_W-1:0] cell_age [STORE_CELLS];
   ret_pkg::ret_cfg_type    trail_cfg = '{ret_pkg::STRONG_RESET, ret_pkg::WEAK_RESET, 1'b0};
   echo_result_type         pending_echoes [$];
   echo_result_type         want;

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int hold_cycles = 0;
   int requests_sent = 0;
   int clears_sent = 0;
   int results_checked = 0;
   int settings_used = 1;
   int mismatches = 0;

   radar_echo_trail_ager_unit #(
      .SPOKE_COUNT(SPOKE_COUNT),
      .SPOKE_CELLS(SPOKE_CELLS),
      .AGE_LIMIT  (AGE_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   function automatic echo_result_type trail_update(echo_request_type r);
      echo_result_type res;
      int unsigned     base;
      res.echo_out  = r.echo;
      res.trail_age = '0;
      res.recolour  = 1'b0;
      if (r.spoke < SPOKE_COUNT && r.radius < SPOKE_CELLS) begin
         base = r.spoke * SPOKE_CELLS;
         if (int'(r.radius) + 1 >= int'(r.spoke_length)) begin
            for (int c = r.radius; c < SPOKE_CELLS; c++) cell_age[base + c] = '0;
         end else begin
            if (r.echo >= trail_cfg.strong_threshold) begin
               cell_age[base + r.radius] = ret_pkg::AGE_W'(1);
            end else if (cell_age[base + r.radius] != 0 &&
                         cell_age[base + r.radius] < AGE_CAP) begin
               cell_age[base + r.radius] = cell_age[base + r.radius] + 1'b1;
            end
            res.trail_age = cell_age[base + r.radius];
            res.recolour  = trail_cfg.recolour_enable && (r.echo < trail_cfg.weak_threshold);
         end
      end
      return res;
   endfunction

   function automatic logic [ret_pkg::ECHO_W-1:0] pick_echo(bit quiet);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return 8'd255;
      if (pick == 1) return 8'd0;
      if (quiet) return 8'($urandom_range(63));
      return 8'($urandom_range(255));
   endfunction

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] word;
      mask = (index == ret_pkg::REG_RECOLOR) ? 32'h1 : 32'hFF;
      word = ($urandom & ~mask) | (value & mask);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         ret_pkg::REG_STRONG:  trail_cfg.strong_threshold = word[7:0];
         ret_pkg::REG_WEAK:    trail_cfg.weak_threshold   = word[7:0];
         ret_pkg::REG_RECOLOR: trail_cfg.recolour_enable  = word[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_request(input echo_request_type r, input logic typed,
                               input echo_result_type typed_want);
      echo_result_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {2'b00, r.spoke_length, r.echo, r.radius, r.spoke};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (r.kind == ret_pkg::KIND_CLEAR) begin
         clears_sent++;
         foreach (cell_age[i]) cell_age[i] = '0;
      end else begin
         predicted = trail_update(r);
         pending_echoes.push_back(typed ? typed_want : predicted);
      end
   endtask

   task automatic drain_results();
      while (pending_echoes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      logic [ret_pkg::SPOKE_W-1:0] spoke_pool [4];
      echo_request_type            r;
      int                          sent;
      int                          n;
      bit                          quiet;
      bit                          broken;
      logic [ret_pkg::LEN_W-1:0]   len;
      spoke_pool[0] = '0;
      spoke_pool[1] = '1;
      spoke_pool[2] = 11'($urandom_range(SPOKE_COUNT - 1));
      spoke_pool[3] = 11'($urandom_range(SPOKE_COUNT - 1));
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 7) begin
            r.spoke = spoke_pool[$urandom_range(3)];
            n       = $urandom_range(2, 20);
            quiet   = 1'($urandom_range(1));
            broken  = ($urandom_range(7) == 0);
            len     = broken ? 10'($urandom_range(1023)) : 10'(n);
            for (int c = 0; c < n; c++) begin
               r.kind         = ret_pkg::KIND_ECHO;
               r.radius       = 9'(c);
               r.echo         = pick_echo(quiet);
               r.spoke_length = len;
               send_request(r, 1'b0, '0);
               sent++;
            end
         end else begin
            r.kind         = ret_pkg::KIND_ECHO;
            r.spoke        = 11'($urandom_range(SPOKE_COUNT - 1));
            r.radius       = 9'($urandom_range(SPOKE_CELLS - 1));
            r.echo         = pick_echo(1'b0);
            r.spoke_length = 10'($urandom_range(1023));
            send_request(r, 1'b0, '0);
            sent++;
         end
      end
      req_tvalid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_echoes.size() == 0) begin
            $error("result with no request waiting: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_echoes.pop_front();
            results_checked++;
            if (rsp_tdata[7:0] !== want.echo_out) begin
               $error("echo_out: expected %0d, got %0d", want.echo_out, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[11:8] !== want.trail_age) begin
               $error("trail_age: expected %0d, got %0d", want.trail_age, rsp_tdata[11:8]);
               mismatches++;
            end
            if (rsp_tuser !== want.recolour) begin
               $error("recolour: expected %0d, got %0d", want.recolour, rsp_tuser);
               mismatches++;
            end
         end
      end
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   initial begin
      #(TIMEOUT_TIME);
      $display("timeout with %0d results outstanding", pending_echoes.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gap_pct = 7;
      recv_gap_pct = 53;
      write_register(ret_pkg::REG_RECOLOR, 32'd1);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end
      req_tvalid <= 1'b0;
      drain_results();
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               write_register(ret_pkg::REG_STRONG, 32'd255);
               write_register(ret_pkg::REG_WEAK, 32'd0);
               write_register(ret_pkg::REG_RECOLOR, 32'd1);
            end
            1: begin
               write_register(ret_pkg::REG_STRONG, 32'd0);
               write_register(ret_pkg::REG_WEAK, 32'd255);
               write_register(ret_pkg::REG_RECOLOR, 32'd1);
            end
            2: begin
               write_register(ret_pkg::REG_STRONG, 32'(ret_pkg::STRONG_RESET));
               write_register(ret_pkg::REG_WEAK, 32'(ret_pkg::WEAK_RESET));
               write_register(ret_pkg::REG_RECOLOR, 32'd0);
            end
            4: begin
               write_register(ret_pkg::REG_STRONG, 32'd128);
               write_register(ret_pkg::REG_WEAK, 32'd128);
               write_register(ret_pkg::REG_RECOLOR, 32'd1);
               write_register(REG_UNUSED, $urandom);
            end
            default: begin
               write_register(ret_pkg::REG_STRONG, 32'($urandom_range(255)));
               write_register(ret_pkg::REG_WEAK, 32'($urandom_range(255)));
               write_register(ret_pkg::REG_RECOLOR, 32'($urandom_range(1)));
            end
         endcase
         settings_used++;
         if (p < 2) begin
            send_gap_pct = 7;
            recv_gap_pct = 53;
         end else if (p < 4) begin
            send_gap_pct = 53;
            recv_gap_pct = 7;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         if (p == 4) hold_cycles = HOLD_CYCLES;
         run_random(PHASE_ITEMS);
         drain_results();
      end
      $display("covered %0d requests (%0d clears) and checked %0d results", requests_sent,
               clears_sent, results_checked);
      $display("over %0d register settings with sender and receiver stalls", settings_used);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
